// ----- rtl/rmsn_pkg.sv -----
package rmsn_pkg;

  localparam int unsigned DATA_BITS  = 16;
  localparam int unsigned MAX_ROW    = 8192;
  localparam int unsigned LEN_W      = 14;
  localparam int unsigned CNT_W      = 13;
  localparam int unsigned EPS_W      = 24;
  localparam int unsigned SUM_W      = 44;
  localparam int unsigned SCALE_W    = 28;
  localparam int unsigned NUM_W      = 57;
  localparam int unsigned DEN_W      = 45;
  localparam int unsigned PROD1_W    = 45;
  localparam int unsigned PROD2_W    = 2 * DATA_BITS;
  localparam int unsigned DIV_STEPS  = NUM_W;
  localparam int unsigned SQRT_STEPS = 29;
  localparam int unsigned STEP_W     = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_RND,
    ST_EMIT,
    ST_DIV_MEAN,
    ST_RECIP,
    ST_DIV_RECIP,
    ST_SQRT_LOAD,
    ST_SQRT,
    ST_SCALE
  } state_e;

  typedef enum logic [1:0] {
    CFG_ROW_LENGTH = 2'd0,
    CFG_EPSILON    = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic acc_en;
    logic norm_en;
    logic mul_en;
    logic rnd_en;
    logic out_load;
    logic div_step;
    logic recip_start;
    logic sqrt_start;
    logic sqrt_step;
    logic scale_load;
    logic scale_max;
  } cmd_t;

  typedef struct packed {
    logic acc_last;
    logic m_zero;
    logic out_free;
  } status_t;

  function automatic logic signed [DATA_BITS-1:0] sat_data(input logic signed [PROD1_W-1:0] v);
    logic signed [PROD1_W-1:0] hi;
    logic signed [PROD1_W-1:0] lo;
    hi = PROD1_W'((1 << (DATA_BITS - 1)) - 1);
    lo = -hi - PROD1_W'(1);
    if (v > hi) return hi[DATA_BITS-1:0];
    else if (v < lo) return lo[DATA_BITS-1:0];
    else return v[DATA_BITS-1:0];
  endfunction

endpackage

// ----- rtl/rms_normalize_row_unit.sv -----
// Row-wise RMS normalization in two passes. Send a row's elements with tuser 0
// to accumulate their squares; they are taken back to back. After the row's
// last one the block computes the Q12.16 scale rsqrt(mean square + epsilon)
// with one shared restoring divider (mean, then reciprocal) and a bit-pair
// square root, stalling input until the scale is loaded; if the mean square
// plus epsilon is zero the scale saturates and only the mean is computed.
// Then send the same elements with tuser 1 and their Q2.14 weights; each passes
// a capture register, two multiply stages and the output register; the next
// is taken once the result is loaded there, even while it waits. tlast marks
// the row's last result. Write configuration only while the block is idle.
module rms_normalize_row_unit import rmsn_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [2*DATA_BITS-1:0]   s_axis_tdata,  // sample, gain
  input  logic                     s_axis_tuser,  // kind
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [DATA_BITS-1:0]     m_axis_tdata,  // normalized
  output logic                     m_axis_tlast,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [1:0]               cfg_index_i,
  input  logic [EPS_W-1:0]         cfg_data_i
);

  logic [LEN_W-1:0] row_length_q;
  logic [EPS_W-1:0] epsilon_q;
  logic [LEN_W-1:0] len;
  cmd_t             cmd;
  status_t          status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q <= LEN_W'(4096);
      epsilon_q    <= EPS_W'(17);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ROW_LENGTH: row_length_q <= cfg_data_i[LEN_W-1:0];
        CFG_EPSILON:    epsilon_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (row_length_q == '0) len = LEN_W'(1);
    else if (row_length_q > LEN_W'(MAX_ROW)) len = LEN_W'(MAX_ROW);
    else len = row_length_q;
  end

  rmsn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rmsn_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .sample_i    (s_axis_tdata[DATA_BITS-1:0]),
    .gain_i      (s_axis_tdata[2*DATA_BITS-1:DATA_BITS]),
    .len_i       (len),
    .eps_i       (epsilon_q),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ----- rtl/rmsn_ctrl.sv -----
module rmsn_ctrl import rmsn_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_kind_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (!in_kind_i) begin
            cmd_o.acc_en = 1'b1;
            if (status_i.acc_last) begin
              state_d = ST_DIV_MEAN;
              step_d  = '0;
            end
          end else begin
            cmd_o.norm_en = 1'b1;
            state_d       = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_RND;
      end
      ST_RND: begin
        cmd_o.rnd_en = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_DIV_MEAN: begin
        cmd_o.div_step = 1'b1;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = ST_RECIP;
          step_d  = '0;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_RECIP: begin
        if (status_i.m_zero) begin
          cmd_o.scale_max = 1'b1;
          state_d         = ST_IDLE;
        end else begin
          cmd_o.recip_start = 1'b1;
          state_d           = ST_DIV_RECIP;
        end
      end
      ST_DIV_RECIP: begin
        cmd_o.div_step = 1'b1;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = ST_SQRT_LOAD;
          step_d  = '0;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_SQRT_LOAD: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (step_q == STEP_W'(SQRT_STEPS - 1)) begin
          state_d = ST_SCALE;
          step_d  = '0;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_SCALE: begin
        cmd_o.scale_load = 1'b1;
        state_d          = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_last_acc_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o && in_valid_i && !in_kind_i && status_i.acc_last) |=> state_q == ST_DIV_MEAN)
    else $error("row end did not start scale computation");

  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> status_i.out_free)
    else $error("output register overwritten");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= STEP_W'(DIV_STEPS - 1))
    else $error("step counter out of range");

  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_MEAN || state_q == ST_SQRT) |-> !in_ready_o)
    else $error("item accepted during scale computation");

endmodule

// ----- rtl/rmsn_dp.sv -----
module rmsn_dp import rmsn_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output status_t              status_o,
  input  logic [DATA_BITS-1:0] sample_i,
  input  logic [DATA_BITS-1:0] gain_i,
  input  logic [LEN_W-1:0]     len_i,
  input  logic [EPS_W-1:0]     eps_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [DATA_BITS-1:0] out_data_o,
  output logic                 out_last_o
);

  logic [SUM_W-1:0]   sum_q;
  logic [CNT_W-1:0]   acc_cnt_q;
  logic [CNT_W-1:0]   emit_cnt_q;
  logic [SCALE_W-1:0] scale_q;

  logic signed [DATA_BITS-1:0] x_q, g_q;
  logic                        end_q;
  logic signed [PROD1_W-1:0]   p1_q;
  logic signed [PROD2_W-1:0]   p2_q;

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] sx_q, sr_q, sbit_q;

  logic                 out_valid_q;
  logic [DATA_BITS-1:0] out_data_q;
  logic                 out_last_q;

  logic signed [PROD2_W-1:0] sq;
  logic [SUM_W-1:0]          sum_next;
  logic                      acc_last, emit_last;
  logic [DEN_W-1:0]          mean_eps;
  logic [DEN_W:0]            rem_sh;
  logic                      div_ge;
  logic [NUM_W:0]            sqrt_trial;
  logic                      sqrt_ge;
  logic signed [PROD1_W-1:0] w1, w2;
  logic signed [DATA_BITS-1:0] t_sat, y_sat;

  assign sq        = $signed(sample_i) * $signed(sample_i);
  assign sum_next  = sum_q + SUM_W'(unsigned'(sq));
  assign acc_last  = ({1'b0, acc_cnt_q} + LEN_W'(1)) >= len_i;
  assign emit_last = ({1'b0, emit_cnt_q} + LEN_W'(1)) >= len_i;

  // mean square in units of 2^-24, quotient of the first division
  assign mean_eps = DEN_W'(num_q[SUM_W-1:0]) + DEN_W'(eps_i);

  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign div_ge = rem_sh >= {1'b0, den_q};

  assign sqrt_trial = {1'b0, sr_q} + {1'b0, sbit_q};
  assign sqrt_ge    = {1'b0, sx_q} >= sqrt_trial;

  // round half up, then saturate
  assign w1    = p1_q + PROD1_W'(1 << 15);
  assign t_sat = sat_data(w1 >>> 16);
  assign w2    = PROD1_W'(p2_q) + PROD1_W'(1 << 13);
  assign y_sat = sat_data(w2 >>> 14);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= '0;
      acc_cnt_q  <= '0;
      emit_cnt_q <= '0;
      scale_q    <= '0;
    end else begin
      if (cmd_i.acc_en) begin
        if (acc_last) begin
          sum_q     <= '0;
          acc_cnt_q <= '0;
        end else begin
          sum_q     <= sum_next;
          acc_cnt_q <= acc_cnt_q + CNT_W'(1);
        end
      end
      if (cmd_i.norm_en) begin
        emit_cnt_q <= emit_last ? '0 : emit_cnt_q + CNT_W'(1);
      end
      if (cmd_i.scale_max) begin
        scale_q <= '1;
      end else if (cmd_i.scale_load) begin
        scale_q <= (sr_q > NUM_W'({SCALE_W{1'b1}})) ? '1 : sr_q[SCALE_W-1:0];
      end
    end
  end

  // shared restoring divider, quotient shifts into num_q
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en && acc_last) begin
      num_q <= NUM_W'(sum_next);
      den_q <= DEN_W'(len_i);
      rem_q <= '0;
    end else if (cmd_i.recip_start) begin
      num_q <= NUM_W'(1) << (NUM_W - 1);
      den_q <= mean_eps;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= div_ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
      num_q <= {num_q[NUM_W-2:0], div_ge};
    end
  end

  // bit-pair integer square root
  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      sx_q   <= num_q;
      sr_q   <= '0;
      sbit_q <= NUM_W'(1) << (NUM_W - 1);
    end else if (cmd_i.sqrt_step) begin
      if (sqrt_ge) begin
        sx_q <= sx_q - sqrt_trial[NUM_W-1:0];
        sr_q <= (sr_q >> 1) + sbit_q;
      end else begin
        sr_q <= sr_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.norm_en) begin
      x_q   <= $signed(sample_i);
      g_q   <= $signed(gain_i);
      end_q <= emit_last;
    end
    if (cmd_i.mul_en) begin
      p1_q <= x_q * $signed({1'b0, scale_q});
    end
    if (cmd_i.rnd_en) begin
      p2_q <= t_sat * g_q;
    end
    if (cmd_i.out_load) begin
      out_data_q <= y_sat;
      out_last_q <= end_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.acc_last = acc_last;
  assign status_o.m_zero   = (mean_eps == '0);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

// ----- tb/rmsn_checker.sv -----
`timescale 1ns / 100ps

module rmsn_checker import rmsn_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [2*DATA_BITS-1:0] s_axis_tdata,
  input  logic                   s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [DATA_BITS-1:0]   m_axis_tdata,
  input  logic                   m_axis_tlast,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [EPS_W-1:0]       cfg_data_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  localparam logic [SCALE_W-1:0] SCALE_SAT = '1;

  typedef struct {
    logic [DATA_BITS-1:0] normalized;
    logic                 row_end;
  } norm_item_t;

  norm_item_t         expected_q[$];
  logic [LEN_W-1:0]   row_len;
  logic [EPS_W-1:0]   eps_raw;
  logic [63:0]        sq_sum;
  int unsigned        acc_cnt;
  int unsigned        emit_cnt;
  logic [SCALE_W-1:0] scale;
  int                 fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

  function automatic int unsigned active_len(logic [LEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > MAX_ROW) return MAX_ROW;
    return len;
  endfunction

  // bitwise integer square root, result below 2^29
  function automatic logic [63:0] int_sqrt(logic [63:0] q);
    logic [63:0] r;
    logic [63:0] t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= q) r = t;
    end
    return r;
  endfunction

  function automatic logic [SCALE_W-1:0] row_rsqrt(logic [63:0] sum, int unsigned len,
                                                   logic [EPS_W-1:0] eps);
    logic [63:0] ms;
    logic [63:0] r;
    ms = sum / len + eps;
    if (ms == 0) return SCALE_SAT;
    r = int_sqrt((64'd1 << 56) / ms);
    return (r > SCALE_SAT) ? SCALE_SAT : r[SCALE_W-1:0];
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    longint     x;
    longint     g;
    longint     t;
    longint     y;
    norm_item_t e;
    int unsigned len;
    if (!rst_ni) begin
      expected_q.delete();
      row_len  = 14'd4096;
      eps_raw  = 24'd17;
      sq_sum   = 0;
      acc_cnt  = 0;
      emit_cnt = 0;
      scale    = 0;
      fails    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_ROW_LENGTH) row_len = cfg_data_i[LEN_W-1:0];
        else if (cfg_index_i == CFG_EPSILON) eps_raw = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        len = active_len(row_len);
        x = longint'($signed(s_axis_tdata[DATA_BITS-1:0]));
        if (!s_axis_tuser) begin
          sq_sum += x * x;
          if (acc_cnt + 1 >= len) begin
            scale   = row_rsqrt(sq_sum, len, eps_raw);
            sq_sum  = 0;
            acc_cnt = 0;
          end else begin
            acc_cnt++;
          end
        end else begin
          g = longint'($signed(s_axis_tdata[2*DATA_BITS-1:DATA_BITS]));
          // round half up is floor of (v + half) with an arithmetic shift
          t = clip16((x * longint'({36'd0, scale}) + 32768) >>> 16);
          y = clip16((t * g + 8192) >>> 14);
          e.normalized = y[DATA_BITS-1:0];
          if (emit_cnt + 1 >= len) begin
            e.row_end = 1'b1;
            emit_cnt  = 0;
          end else begin
            e.row_end = 1'b0;
            emit_cnt++;
          end
          expected_q.push_back(e);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected item: normalized %0d, row_end %0d",
                 $signed(m_axis_tdata), m_axis_tlast);
          fails++;
        end else begin
          e = expected_q.pop_front();
          if (m_axis_tdata !== e.normalized) begin
            $error("normalized: expected %0d, actual %0d",
                   $signed(e.normalized), $signed(m_axis_tdata));
            fails++;
          end
          if (m_axis_tlast !== e.row_end) begin
            $error("row_end: expected %0d, actual %0d", e.row_end, m_axis_tlast);
            fails++;
          end
        end
      end
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top import rmsn_pkg::*; ();

  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;
  localparam int         STALL_LIMIT = 5000;
  localparam int         SCALE_WAIT  = 200;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [2*DATA_BITS-1:0] s_axis_tdata = '0;  // sample, gain
  logic                   s_axis_tuser = 1'b0;  // kind
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [DATA_BITS-1:0]   m_axis_tdata;  // normalized
  logic                   m_axis_tlast;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [1:0]             cfg_index_i = '0;
  logic [EPS_W-1:0]       cfg_data_i = '0;
  int                     fail_count;
  int                     pending;
  logic                   src_idle_on = 1'b0;
  logic                   sink_stall_on = 1'b0;
  int                     sink_hold = 0;
  int                     quiet_cycles = 0;
  int                     items_sent = 0;

  always #5 clk_i = ~clk_i;

  rms_normalize_row_unit uut (.*);

  rmsn_checker chk (
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .*
  );

  always @(posedge clk_i) begin
    if (!sink_stall_on) begin
      m_axis_tready <= 1'b1;
    end else if (sink_hold > 0) begin
      sink_hold--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 9) < 7) begin
      m_axis_tready <= 1'b1;
    end else begin
      sink_hold = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(15, 40);
      m_axis_tready <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("rms_normalize_row_unit test failed");
        $finish;
      end
    end
  end

  task automatic send(input logic kind, input logic [15:0] sample, input logic [15:0] gain);
    int  gap;
    bit  took;
    gap = 0;
    if (src_idle_on && $urandom_range(0, 3) == 0)
      gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(15, 40);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {gain, sample};
    do begin
      @(negedge clk_i);
      took = s_axis_tready;
      @(posedge clk_i);
    end while (!took);
    items_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    // the scale computation may still be running
    repeat (SCALE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [EPS_W-1:0] val);
    bit took;
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(negedge clk_i);
      took = cfg_ready_o;
      @(posedge clk_i);
    end while (!took);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_row(input int n);
    logic [15:0] row[$];
    for (int i = 0; i < n; i++) begin
      row.push_back(rand_sample());
      send(1'b0, row[i], 16'($urandom()));
    end
    for (int i = 0; i < n; i++) begin
      // occasionally a stray element disturbs the sequence
      if ($urandom_range(0, 29) == 0) send(1'($urandom()), rand_sample(), 16'($urandom()));
      send(1'b1, row[i], 16'($urandom()));
    end
  endtask

  initial begin
    int len;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // normalize before any row has set a scale
    send(1'b1, 16'h7FFF, 16'h7FFF);
    send(1'b1, 16'h8000, 16'h8000);
    // zero mean square saturates the scale
    write_reg(CFG_ROW_LENGTH, 24'd1);
    write_reg(CFG_EPSILON, 24'd0);
    send(1'b0, 16'h0000, 16'hFFFF);
    send(1'b1, 16'h7FFF, 16'h7FFF);
    send(1'b1, 16'h8000, 16'h7FFF);
    send(1'b1, 16'h0001, 16'h8000);
    send(1'b1, 16'hFFFF, 16'h0000);
    write_reg(CFG_SPARE_A, 24'($urandom()));
    write_reg(CFG_SPARE_B, 24'($urandom()));
    // zero length acts as one
    write_reg(CFG_ROW_LENGTH, 24'd0);
    send(1'b0, 16'h8000, 16'h0000);
    send(1'b1, 16'h8000, 16'h7FFF);
    send(1'b1, 16'h7FFF, 16'h8000);
    write_reg(CFG_EPSILON, 24'hFFFFFF);
    write_reg(CFG_ROW_LENGTH, 24'd3);
    send(1'b0, 16'h7FFF, 16'h0);
    send(1'b0, 16'h8000, 16'h0);
    send(1'b0, 16'h1000, 16'h0);
    send(1'b1, 16'h7FFF, 16'h4000);
    send(1'b1, 16'h8000, 16'hC000);
    send(1'b1, 16'h1000, 16'h7FFF);
    // length shortened in the middle of a row
    write_reg(CFG_EPSILON, 24'd17);
    write_reg(CFG_ROW_LENGTH, 24'd5);
    send(1'b0, 16'h0800, 16'h0);
    send(1'b0, 16'hF800, 16'h0);
    send(1'b0, 16'h0400, 16'h0);
    send(1'b1, 16'h0800, 16'h4000);
    write_reg(CFG_ROW_LENGTH, 24'd2);
    send(1'b0, 16'h0200, 16'h0);
    send(1'b1, 16'h0200, 16'h4000);
    send(1'b1, 16'h0200, 16'h4000);

    while (items_sent < 620) begin
      src_idle_on   <= ($urandom_range(0, 3) != 0);
      sink_stall_on <= ($urandom_range(0, 3) != 0);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 32) : $urandom_range(1, 12);
      write_reg(CFG_ROW_LENGTH, 24'(len));
      case ($urandom_range(0, 3))
        0:       write_reg(CFG_EPSILON, 24'd0);
        1:       write_reg(CFG_EPSILON, 24'hFFFFFF);
        2:       write_reg(CFG_EPSILON, 24'($urandom_range(0, 4096)));
        default: write_reg(CFG_EPSILON, 24'($urandom()));
      endcase
      repeat ($urandom_range(1, 2)) send_row(len);
      // sometimes leave a row unfinished before the next setting
      if ($urandom_range(0, 4) == 0) send_row($urandom_range(1, len));
    end

    // register above the limit clamps, so a short row does not end
    src_idle_on   <= 1'b0;
    sink_stall_on <= 1'b0;
    write_reg(CFG_ROW_LENGTH, 24'h3FFF);
    write_reg(CFG_EPSILON, 24'd17);
    send_row(20);

    drain();
    if (fail_count == 0) begin
      $display("rms_normalize_row_unit test passed");
    end else begin
      $display("rms_normalize_row_unit test failed");
    end
    $finish;
  end

endmodule
